// File: hdl/tsqm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tsqm_pkg;

    localparam int MAX_SLOTS   = 16;
    localparam int NUM_STAGES  = 4;

    localparam int SLOT_W      = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int LINK_W      = $clog2(MAX_SLOTS + 1);
    localparam int STAGE_W     = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
    localparam int COUNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int INIT_LEN    = (MAX_SLOTS > NUM_STAGES) ? MAX_SLOTS : NUM_STAGES;
    localparam int IDX_W       = $clog2(INIT_LEN + 1);

    localparam int ACTION_W    = 2;
    localparam int STAGE_IN_W  = 3;
    localparam int SLOT_IN_W   = 4;
    localparam int CODE_W      = 2;
    localparam int HEAD_W      = 4;
    localparam int REPORT_W    = 5;
    localparam int TASKS_W     = 5;

    localparam int TASKS_RESET = 16;
    localparam int RESET_N     = (TASKS_RESET > MAX_SLOTS) ? MAX_SLOTS : TASKS_RESET;

    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(MAX_SLOTS);

    typedef enum logic [ACTION_W-1:0] {
        ACT_INIT  = 2'd0,
        ACT_HEAD  = 2'd1,
        ACT_MOVE  = 2'd2,
        ACT_QUERY = 2'd3
    } action_t;

    typedef enum logic [CODE_W-1:0] {
        CODE_OK        = 2'd0,
        CODE_EMPTY     = 2'd1,
        CODE_BAD_STAGE = 2'd2,
        CODE_BAD_SLOT  = 2'd3
    } code_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_RD_SLOT,
        ST_UNLINK_PREV,
        ST_UNLINK_NEXT,
        ST_APPEND_SLOT,
        ST_APPEND_TAIL,
        ST_RESP
    } state_t;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LATCH,
        DP_INIT_STEP,
        DP_RD_SLOT,
        DP_UNLINK_PREV,
        DP_UNLINK_NEXT,
        DP_APPEND_SLOT,
        DP_APPEND_TAIL,
        DP_REPORT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic in_init;
        logic in_move_ok;
        logic init_last;
    } dp_status_t;

    function automatic logic [REPORT_W-1:0] sat_count(input logic [COUNT_W-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return (w > 32'd31) ? REPORT_W'(31) : w[REPORT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: hdl/tsqm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tsqm_ctrl
    import tsqm_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire        m_tready,
    output logic       m_tvalid,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (status.in_init)
                        state_next = ST_INIT;
                    else if (status.in_move_ok)
                        state_next = ST_RD_SLOT;
                    else
                        state_next = ST_RESP;
                end
            end
            ST_INIT:
            begin
                if (status.init_last)
                    state_next = ST_RESP;
            end
            ST_RD_SLOT:     state_next = ST_UNLINK_PREV;
            ST_UNLINK_PREV: state_next = ST_UNLINK_NEXT;
            ST_UNLINK_NEXT: state_next = ST_APPEND_SLOT;
            ST_APPEND_SLOT: state_next = ST_APPEND_TAIL;
            ST_APPEND_TAIL: state_next = ST_RESP;
            ST_RESP:
            begin
                if (!out_valid_reg || m_tready)
                    state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        cmd.op   = DP_NONE;
        load     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                    cmd.op = DP_LATCH;
            end
            ST_INIT:        cmd.op = DP_INIT_STEP;
            ST_RD_SLOT:     cmd.op = DP_RD_SLOT;
            ST_UNLINK_PREV: cmd.op = DP_UNLINK_PREV;
            ST_UNLINK_NEXT: cmd.op = DP_UNLINK_NEXT;
            ST_APPEND_SLOT: cmd.op = DP_APPEND_SLOT;
            ST_APPEND_TAIL: cmd.op = DP_APPEND_TAIL;
            ST_RESP:
            begin
                load = !out_valid_reg || m_tready;
                if (load)
                    cmd.op = DP_REPORT;
            end
        endcase
        out_valid_next = load || (out_valid_reg && !m_tready);
    end

    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

// File: hdl/tsqm_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module tsqm_dpath
    import tsqm_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  dp_cmd_t              cmd,
    output dp_status_t           status,
    input  wire [ACTION_W-1:0]   in_action,
    input  wire [STAGE_IN_W-1:0] in_stage,
    input  wire [SLOT_IN_W-1:0]  in_slot,
    input  wire                  cfg_we,
    input  wire [TASKS_W-1:0]    cfg_wdata,
    output code_t                res_code,
    output logic [HEAD_W-1:0]    res_head,
    output logic [REPORT_W-1:0]  res_count,
    output logic                 res_empty
);

    logic [LINK_W-1:0]  next_link_reg   [MAX_SLOTS];
    logic [LINK_W-1:0]  prev_link_reg   [MAX_SLOTS];
    logic [STAGE_W-1:0] slot_stage_reg  [MAX_SLOTS];
    logic [LINK_W-1:0]  queue_head_reg  [NUM_STAGES];
    logic [LINK_W-1:0]  queue_tail_reg  [NUM_STAGES];
    logic [COUNT_W-1:0] queue_count_reg [NUM_STAGES];

    logic [TASKS_W-1:0] tasks_reg;
    logic [COUNT_W-1:0] active_reg;
    logic [IDX_W-1:0]   idx_reg;
    action_t            action_reg;
    logic [STAGE_W-1:0] stage_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic               stage_bad_reg;
    logic               slot_bad_reg;
    logic [STAGE_W-1:0] st_reg;
    logic [LINK_W-1:0]  p_reg;
    logic [LINK_W-1:0]  n_reg;
    logic [LINK_W-1:0]  t_reg;
    code_t              code_reg;
    logic [HEAD_W-1:0]  head_reg;
    logic [REPORT_W-1:0] count_reg;
    logic               empty_reg;

    logic               in_stage_bad;
    logic               in_slot_bad;
    logic [COUNT_W-1:0] tasks_clamped;
    logic [STAGE_W-1:0] q_addr;
    logic [LINK_W-1:0]  q_head_rd;
    logic [LINK_W-1:0]  q_tail_rd;
    logic [COUNT_W-1:0] q_count_rd;
    logic [31:0]        i32;
    logic [31:0]        n32;

    code_t               rep_code;
    logic [HEAD_W-1:0]   rep_head;
    logic [REPORT_W-1:0] rep_count;
    logic                rep_empty;

    logic               nl_we, pl_we, ss_we, qh_we, qt_we, qc_we;
    logic [SLOT_W-1:0]  nl_addr, pl_addr, ss_addr;
    logic [STAGE_W-1:0] qh_addr, qt_addr, qc_addr;
    logic [LINK_W-1:0]  nl_data, pl_data, qh_data, qt_data;
    logic [STAGE_W-1:0] ss_data;
    logic [COUNT_W-1:0] qc_data;

    assign in_stage_bad  = 32'(in_stage) >= 32'(NUM_STAGES);
    assign in_slot_bad   = (32'(in_slot) >= 32'(active_reg)) ||
                           (32'(in_slot) >= 32'(MAX_SLOTS));
    assign tasks_clamped = (32'(tasks_reg) > 32'(MAX_SLOTS)) ? COUNT_W'(MAX_SLOTS)
                                                               : COUNT_W'(tasks_reg);

    assign status.in_init    = action_t'(in_action) == ACT_INIT;
    assign status.in_move_ok = (action_t'(in_action) == ACT_MOVE) && !in_stage_bad &&
                               !in_slot_bad;
    assign status.init_last  = idx_reg == IDX_W'(INIT_LEN - 1);

    always_comb
    begin
        if (cmd.op == DP_UNLINK_NEXT)
            q_addr = st_reg;
        else if (action_reg == ACT_INIT)
            q_addr = '0;
        else
            q_addr = stage_reg;
    end

    assign q_head_rd  = queue_head_reg[q_addr];
    assign q_tail_rd  = queue_tail_reg[q_addr];
    assign q_count_rd = queue_count_reg[q_addr];
    assign i32        = 32'(idx_reg);
    assign n32        = 32'(active_reg);

    always_comb
    begin
        nl_we = 1'b0; nl_addr = slot_reg; nl_data = LINK_NULL;
        pl_we = 1'b0; pl_addr = slot_reg; pl_data = LINK_NULL;
        ss_we = 1'b0; ss_addr = slot_reg; ss_data = stage_reg;
        qh_we = 1'b0; qh_addr = stage_reg; qh_data = LINK_NULL;
        qt_we = 1'b0; qt_addr = stage_reg; qt_data = LINK_NULL;
        qc_we = 1'b0; qc_addr = stage_reg; qc_data = q_count_rd;
        case (cmd.op)
            DP_INIT_STEP:
            begin
                if (i32 < 32'(MAX_SLOTS))
                begin
                    nl_we   = 1'b1;
                    pl_we   = 1'b1;
                    ss_we   = 1'b1;
                    nl_addr = idx_reg[SLOT_W-1:0];
                    pl_addr = idx_reg[SLOT_W-1:0];
                    ss_addr = idx_reg[SLOT_W-1:0];
                    ss_data = '0;
                    nl_data = (i32 + 32'd1 < n32) ? LINK_W'(i32 + 32'd1) : LINK_NULL;
                    pl_data = (i32 == 32'd0 || i32 >= n32) ? LINK_NULL
                                                           : LINK_W'(i32 - 32'd1);
                end
                if (i32 < 32'(NUM_STAGES))
                begin
                    qh_we   = 1'b1;
                    qt_we   = 1'b1;
                    qc_we   = 1'b1;
                    qh_addr = idx_reg[STAGE_W-1:0];
                    qt_addr = idx_reg[STAGE_W-1:0];
                    qc_addr = idx_reg[STAGE_W-1:0];
                    qh_data = (i32 == 32'd0 && n32 > 32'd0) ? '0 : LINK_NULL;
                    qt_data = (i32 == 32'd0 && n32 > 32'd0) ? LINK_W'(n32 - 32'd1)
                                                            : LINK_NULL;
                    qc_data = (i32 == 32'd0) ? active_reg : '0;
                end
            end
            DP_UNLINK_PREV:
            begin
                if (p_reg != LINK_NULL)
                begin
                    nl_we   = 1'b1;
                    nl_addr = p_reg[SLOT_W-1:0];
                    nl_data = n_reg;
                end
                else
                begin
                    qh_we   = 1'b1;
                    qh_addr = st_reg;
                    qh_data = n_reg;
                end
            end
            DP_UNLINK_NEXT:
            begin
                if (n_reg != LINK_NULL)
                begin
                    pl_we   = 1'b1;
                    pl_addr = n_reg[SLOT_W-1:0];
                    pl_data = p_reg;
                end
                else
                begin
                    qt_we   = 1'b1;
                    qt_addr = st_reg;
                    qt_data = p_reg;
                end
                qc_we   = 1'b1;
                qc_addr = st_reg;
                qc_data = (q_count_rd != '0) ? q_count_rd - COUNT_W'(1) : q_count_rd;
            end
            DP_APPEND_SLOT:
            begin
                pl_we   = 1'b1;
                pl_data = q_tail_rd;
                nl_we   = 1'b1;
                nl_data = LINK_NULL;
            end
            DP_APPEND_TAIL:
            begin
                if (t_reg != LINK_NULL)
                begin
                    nl_we   = 1'b1;
                    nl_addr = t_reg[SLOT_W-1:0];
                    nl_data = LINK_W'(slot_reg);
                end
                else
                begin
                    qh_we   = 1'b1;
                    qh_data = LINK_W'(slot_reg);
                end
                qt_we   = 1'b1;
                qt_data = LINK_W'(slot_reg);
                qc_we   = 1'b1;
                qc_data = q_count_rd + COUNT_W'(1);
                ss_we   = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        rep_code  = CODE_OK;
        rep_head  = '0;
        rep_count = sat_count(q_count_rd);
        rep_empty = q_count_rd == '0;
        if (action_reg != ACT_INIT)
        begin
            if (stage_bad_reg)
            begin
                rep_code  = CODE_BAD_STAGE;
                rep_count = '0;
                rep_empty = 1'b0;
            end
            else if (action_reg == ACT_HEAD)
            begin
                if (q_count_rd == '0 || q_head_rd == LINK_NULL)
                begin
                    rep_code  = CODE_EMPTY;
                    rep_count = '0;
                    rep_empty = 1'b1;
                end
                else
                    rep_head = HEAD_W'(q_head_rd);
            end
            else if (action_reg == ACT_MOVE && slot_bad_reg)
            begin
                rep_code  = CODE_BAD_SLOT;
                rep_count = '0;
                rep_empty = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_SLOTS; k++)
            begin
                next_link_reg[k]  <= (k + 1 < RESET_N) ? LINK_W'(k + 1) : LINK_NULL;
                prev_link_reg[k]  <= (k == 0 || k >= RESET_N) ? LINK_NULL : LINK_W'(k - 1);
                slot_stage_reg[k] <= '0;
            end
            for (int k = 0; k < NUM_STAGES; k++)
            begin
                queue_head_reg[k]  <= (k == 0 && RESET_N > 0) ? '0 : LINK_NULL;
                queue_tail_reg[k]  <= (k == 0 && RESET_N > 0) ? LINK_W'(RESET_N - 1)
                                                              : LINK_NULL;
                queue_count_reg[k] <= (k == 0) ? COUNT_W'(RESET_N) : '0;
            end
            tasks_reg  <= TASKS_W'(TASKS_RESET);
            active_reg <= COUNT_W'(RESET_N);
            idx_reg    <= '0;
            action_reg <= ACT_QUERY;
        end
        else
        begin
            if (nl_we)
                next_link_reg[nl_addr] <= nl_data;
            if (pl_we)
                prev_link_reg[pl_addr] <= pl_data;
            if (ss_we)
                slot_stage_reg[ss_addr] <= ss_data;
            if (qh_we)
                queue_head_reg[qh_addr] <= qh_data;
            if (qt_we)
                queue_tail_reg[qt_addr] <= qt_data;
            if (qc_we)
                queue_count_reg[qc_addr] <= qc_data;
            if (cfg_we)
                tasks_reg <= cfg_wdata;
            if (cmd.op == DP_LATCH)
            begin
                action_reg <= action_t'(in_action);
                idx_reg    <= '0;
                if (action_t'(in_action) == ACT_INIT)
                    active_reg <= tasks_clamped;
            end
            else if (cmd.op == DP_INIT_STEP)
                idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_LATCH:
            begin
                stage_reg     <= STAGE_W'(in_stage);
                slot_reg      <= SLOT_W'(in_slot);
                stage_bad_reg <= in_stage_bad;
                slot_bad_reg  <= in_slot_bad;
            end
            DP_RD_SLOT:
            begin
                st_reg <= slot_stage_reg[slot_reg];
                p_reg  <= prev_link_reg[slot_reg];
                n_reg  <= next_link_reg[slot_reg];
            end
            DP_APPEND_SLOT:
                t_reg <= q_tail_rd;
            DP_REPORT:
            begin
                code_reg  <= rep_code;
                head_reg  <= rep_head;
                count_reg <= rep_count;
                empty_reg <= rep_empty;
            end
            default:
            begin
            end
        endcase
    end

    assign res_code  = code_reg;
    assign res_head  = head_reg;
    assign res_count = count_reg;
    assign res_empty = empty_reg;

endmodule

`default_nettype wire

// File: hdl/task_stage_queue_manager_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                  Contents
// request   in         s_tvalid / s_tready        s_tuser: action; s_tdata: stage, slot
// result    out        m_tvalid / m_tready        m_tuser: code; m_tdata: head, count, empty
// config    in         cfg_we                     cfg_wdata: tasks_in_use
//
// Head and query go from the accepted request straight to the result; move steps through a
// slot read, two unlink writes and two append writes through the single-address link and
// queue arrays, and init sweeps INIT_LEN entries, the larger of the slot and stage counts.
// Reset leaves every slot chained in the idle queue at once; there is no clearing pass.
// A finished result waits in the output register while the next request is accepted; that
// request stalls in its last cycle until the register has been emptied.

module task_stage_queue_manager_core
    import tsqm_pkg::*;
(
    input  wire               clk,
    input  wire               rst_n,
    input  wire               s_tvalid,
    output logic              s_tready,
    input  wire [7:0]         s_tdata,   // stage [2:0], slot [6:3], zero [7]
    input  wire [1:0]         s_tuser,   // action [1:0]
    output logic              m_tvalid,
    input  wire               m_tready,
    output logic [15:0]       m_tdata,   // head_slot [3:0], count [8:4],
                                         // stage_empty [9], zero [15:10]
    output logic [1:0]        m_tuser,   // code [1:0]
    input  wire               cfg_we,
    input  wire [TASKS_W-1:0] cfg_wdata
);

    dp_cmd_t             cmd;
    dp_status_t          status;
    code_t               res_code;
    logic [HEAD_W-1:0]   res_head;
    logic [REPORT_W-1:0] res_count;
    logic                res_empty;

    tsqm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .status   (status),
        .cmd      (cmd)
    );

    tsqm_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_action (s_tuser),
        .in_stage  (s_tdata[2:0]),
        .in_slot   (s_tdata[6:3]),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .res_code  (res_code),
        .res_head  (res_head),
        .res_count (res_count),
        .res_empty (res_empty)
    );

    assign m_tdata = {6'b0, res_empty, res_count, res_head};
    assign m_tuser = res_code;

    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("A request was accepted while the previous one was still in work.");

    a_short_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid &&
        (s_tuser == ACT_HEAD || s_tuser == ACT_QUERY) |=> ##1 m_tvalid)
        else $error("A head or query result did not appear two cycles after its transfer.");

    a_empty_report: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == CODE_EMPTY) |-> (m_tdata[8:0] == 9'd0) && m_tdata[9])
        else $error("An empty-stage result carries a slot or a count.");

endmodule

`default_nettype wire
